/* src/assert_macros.svh */
// assertion macros for the rtl files, used by the divider cell
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, muted while rst_n is low
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`endif

/* src/rgbhl_pkg.sv */
// types and constants of the rgb to hue and lightness palette converter
`timescale 1ns / 1ps

package rgbhl_pkg;

  localparam int CHAN_W   = 8;
  localparam int NUM_W    = 11;
  localparam int DVS_W    = 10;
  localparam int IDX_W    = 4;
  localparam int NUM_CELLS = IDX_W;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 16;
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  // work in flight along the divider row
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [IDX_W-1:0] quo;
    logic [IDX_W-1:0] light;
    logic             grey;
  } tok_t;

endpackage

/* src/rgb_to_hue_luma_palette.sv */
// Converts a stream of 8-bit RGB pixels into 16-bit palette words: from the
// high nibble down, lightness, hue, hue and lightness index. One pixel is
// accepted per clock while the output is ready, and the pipeline is five
// registers deep: the front register, then the four divider cell registers.
// One front cell forms max, min, the lightness index and the hue numerator,
// then a row of four divider cells each settles one bit of the hue quotient.
// The last cell's register is the output register; every cell has its own
// valid bit and accepts new work whenever it is empty or its neighbor takes
// its data. No reset sweep, no configuration.
`timescale 1ns / 1ps

module rgb_to_hue_luma_palette (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rgbhl_pkg::IN_W-1:0]  in_tdata,   // red in the low byte, then green, blue in the high byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rgbhl_pkg::OUT_W-1:0] out_tdata   // light, hue, hue, light nibbles, high first
);
  import rgbhl_pkg::*;

  logic             vld [NUM_CELLS+1];
  logic             rdy [NUM_CELLS+1];
  tok_t             tok [NUM_CELLS+1];
  logic [IDX_W-1:0] hue;
  tok_t             last_tok;

  rgbhl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .red      (in_tdata[CHAN_W-1:0]),
    .green    (in_tdata[2*CHAN_W-1:CHAN_W]),
    .blue     (in_tdata[3*CHAN_W-1:2*CHAN_W]),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_tok   (tok[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rgbhl_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_tok   (tok[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_tok   (tok[i+1])
    );
  end

  assign rdy[NUM_CELLS] = out_tready;
  assign out_tvalid     = vld[NUM_CELLS];
  assign last_tok       = tok[NUM_CELLS];
  assign hue            = last_tok.grey ? '0 : last_tok.quo;
  assign out_tdata      = {last_tok.light, hue, hue, last_tok.light};

endmodule

/* src/rgbhl_front.sv */
// front cell: extremes, lightness index and hue numerator of one pixel
`timescale 1ns / 1ps

module rgbhl_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [rgbhl_pkg::CHAN_W-1:0] red,
  input  logic [rgbhl_pkg::CHAN_W-1:0] green,
  input  logic [rgbhl_pkg::CHAN_W-1:0] blue,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output rgbhl_pkg::tok_t             dn_tok
);
  import rgbhl_pkg::*;

  logic              valid_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] dd;
  logic [NUM_W-1:0]  d_w;
  logic [CHAN_W:0]   sum_s;
  logic [11:0]       lx;
  logic [12:0]       lq;
  logic [4:0]        light_raw;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dd  = mx - mn;
    d_w = NUM_W'(dd);

    // x / 255 for x below 65535 is (x + (x >> 8) + 1) >> 8
    sum_s     = {1'b0, mx} + {1'b0, mn};
    lx        = {sum_s, 3'b000};
    lq        = {1'b0, lx} + 13'(lx[11:8]) + 13'd1;
    light_raw = lq[12:8];

    tok_nxt.quo   = '0;
    tok_nxt.grey  = (mx == mn);
    tok_nxt.dvs   = {2'b00, dd} + {1'b0, dd, 1'b0};
    tok_nxt.light = (light_raw > 5'(IDX_MAX)) ? IDX_MAX : light_raw[IDX_W-1:0];
    priority if (mx == red) begin
      if (green < blue) begin
        tok_nxt.rem = (d_w * NUM_W'(6)) - NUM_W'(blue - green);
      end else begin
        tok_nxt.rem = NUM_W'(green - blue);
      end
    end else if (mx == green) begin
      tok_nxt.rem = {d_w[NUM_W-2:0], 1'b0} + NUM_W'(blue) - NUM_W'(red);
    end else begin
      tok_nxt.rem = {d_w[NUM_W-3:0], 2'b00} + NUM_W'(red) - NUM_W'(green);
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

/* src/rgbhl_div_cell.sv */
// divider cell: one restoring step of the hue quotient per cell
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgbhl_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rgbhl_pkg::tok_t up_tok,
  output logic            dn_valid,
  input  logic            dn_ready,
  output rgbhl_pkg::tok_t dn_tok
);
  import rgbhl_pkg::*;

  logic             valid_r;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             qbit;
  logic [NUM_W-1:0] diff;

  always_comb begin
    qbit    = (up_tok.rem >= NUM_W'(up_tok.dvs));
    diff    = qbit ? (up_tok.rem - NUM_W'(up_tok.dvs)) : up_tok.rem;
    tok_nxt = up_tok;
    tok_nxt.rem = {diff[NUM_W-2:0], 1'b0};
    tok_nxt.quo = {up_tok.quo[IDX_W-2:0], qbit};
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  // partial remainder stays below twice the divisor unless the pixel is grey
  `ASSERT_CLK(a_rem_bound, valid_r |-> (tok_r.grey || (tok_r.rem < {tok_r.dvs, 1'b0})))
  // zero divisor exactly for grey pixels
  `ASSERT_CLK(a_grey_dvs, valid_r |-> ((tok_r.dvs == '0) == tok_r.grey))
  // a stalled cell keeps its work
  `ASSERT_CLK(a_stall_hold, (valid_r && !dn_ready) |=> (valid_r && $stable(tok_r)))

endmodule
